/* rtl/core/bpcs_pkg.sv */
`default_nettype none

package bpcs_pkg;

  // Default sizes handed to the top level.
  localparam int MAX_PATTERN_BYTES_DEF = 16;
  localparam int POSITION_BITS_DEF     = 16;

  // The pattern registers always carry sixteen bytes.
  localparam int PATTERN_BYTES_ALL = 16;
  localparam int PAT_IDX_W         = 4;
  localparam int PATTERN_W         = PATTERN_BYTES_ALL * 8;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_PATTERN_LENGTH = 3'd2,
    CFG_SEARCH_OFFSET  = 3'd3,
    CFG_SEARCH_DEPTH   = 3'd4,
    CFG_IGNORE_CASE    = 3'd5
  } cfg_reg_t;

  // ASCII case folding constants.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef logic [7:0] byte_t;

  // Folds an ASCII capital to lower case when case is to be ignored.
  function automatic byte_t fold_byte(input byte_t c, input logic nocase);
    byte_t res;
    res = c;
    if (nocase && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
      res = c + CASE_OFFSET;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bounded_payload_content_search.sv */
// Searches a packet payload, taken one byte per transfer, for a configured pattern of
// 1 to MAX_PATTERN_BYTES bytes whose start lies at or after search_offset and, when
// search_depth is nonzero, before search_offset + search_depth, optionally ignoring ASCII
// case. Unless a last byte is held, a byte is taken every cycle; each byte passes an
// input register and the compare against the byte history, and on the byte marked last
// the found flag is loaded into the result register, which delivers it, as that byte
// leaves the input register, and the packet state clears. The only stall comes from the
// result side: a last byte waits in the input register while an earlier result has not
// been taken. The pattern is realigned to the pattern length in a register behind the
// configuration registers, through which a pattern or length write reaches the compare.
`default_nettype none

module bounded_payload_content_search
  import bpcs_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  parameter int POSITION_BITS     = POSITION_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // Configuration writes
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [CFG_INDEX_W-1:0] cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data,
  // Payload bytes
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  [7:0]             in_payload_byte,
  input  wire                    in_last_byte,
  // Per-packet result
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic                   out_match_found
);

  localparam int HIST_LEN = MAX_PATTERN_BYTES - 1;
  localparam int LEN_W    = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int CMP_W    = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 2;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  // Configuration registers
  logic [63:0] pattern_low_r;
  logic [63:0] pattern_high_r;
  logic [4:0]  pattern_length_r;
  logic [15:0] search_offset_r;
  logic [15:0] search_depth_r;
  logic        ignore_case_r;

  // Derived pattern, aligned so that byte k faces the payload byte k places back
  byte_t              algn_r [MAX_PATTERN_BYTES];
  byte_t              algn_nxt [MAX_PATTERN_BYTES];
  logic               care_r [MAX_PATTERN_BYTES];
  logic               care_nxt [MAX_PATTERN_BYTES];
  logic [LEN_W-1:0]   len_r;
  logic [LEN_W-1:0]   len_nxt;

  // Input register
  logic  s1_vld_r;
  logic  s1_vld_nxt;
  byte_t s1_byte_r;
  logic  s1_last_r;
  logic  s1_adv;
  logic  in_xfer;

  // Packet state
  byte_t                  hist_r [HIST_LEN];
  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] pos_nxt;
  logic                   found_r;
  logic                   found_nxt;

  // Result register
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_match_found_r;

  // Compare signals
  byte_t            win [MAX_PATTERN_BYTES];
  logic             byte_ok [MAX_PATTERN_BYTES];
  logic             all_ok;
  logic [CMP_W-1:0] pos_inc;
  logic [CMP_W-1:0] start_pos;
  logic [CMP_W-1:0] win_lo;
  logic [CMP_W-1:0] win_hi;
  logic             enough_bytes;
  logic             in_window;
  logic             hit;

  logic [PATTERN_W-1:0]     pat_vec;
  logic [PATTERN_W-1:0]     rev_vec;
  logic [PATTERN_W-1:0]     shf_vec;
  logic [PAT_IDX_W-1:0]     shift_bytes;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= 5'd1;
      search_offset_r  <= '0;
      search_depth_r   <= '0;
      ignore_case_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN_LOW:    pattern_low_r    <= cfg_data;
        CFG_PATTERN_HIGH:   pattern_high_r   <= cfg_data;
        CFG_PATTERN_LENGTH: pattern_length_r <= cfg_data[4:0];
        CFG_SEARCH_OFFSET:  search_offset_r  <= cfg_data[15:0];
        CFG_SEARCH_DEPTH:   search_depth_r   <= cfg_data[15:0];
        CFG_IGNORE_CASE:    ignore_case_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the pattern length and align the pattern to it. A zero length counts as one.
  always_comb begin
    if (pattern_length_r == 5'd0) begin
      len_nxt = LEN_W'(1);
    end else if (int'(pattern_length_r) > MAX_PATTERN_BYTES) begin
      len_nxt = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len_nxt = LEN_W'(pattern_length_r);
    end

    pat_vec = {pattern_high_r, pattern_low_r};
    for (int j = 0; j < PATTERN_BYTES_ALL; j++) begin
      rev_vec[8*j +: 8] = pat_vec[8*(PATTERN_BYTES_ALL-1-j) +: 8];
    end
    // Byte k of the shifted vector is pattern byte len-1-k.
    shift_bytes = PAT_IDX_W'(PATTERN_BYTES_ALL - int'(len_nxt));
    shf_vec     = rev_vec >> {shift_bytes, 3'b000};

    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      algn_nxt[k] = fold_byte(shf_vec[8*k +: 8], ignore_case_r);
      care_nxt[k] = (k < int'(len_nxt));
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      algn_r[k] <= algn_nxt[k];
      care_r[k] <= care_nxt[k];
    end
  end

  // Input stage handshake: a last byte waits only for room in the result register.
  assign s1_adv   = s1_vld_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_xfer) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_payload_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Byte compare of the current byte and the history against the aligned pattern.
  always_comb begin
    win[0] = s1_byte_r;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      win[k] = hist_r[k-1];
    end
    all_ok = 1'b1;
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      byte_ok[k] = !care_r[k] || (fold_byte(win[k], ignore_case_r) == algn_r[k]);
      all_ok     = all_ok && byte_ok[k];
    end
  end

  // Start position window check.
  always_comb begin
    pos_inc      = CMP_W'(pos_r) + CMP_W'(1);
    enough_bytes = (pos_inc >= CMP_W'(len_r));
    start_pos    = pos_inc - CMP_W'(len_r);
    win_lo       = CMP_W'(search_offset_r);
    win_hi       = win_lo + CMP_W'(search_depth_r);
    in_window    = (start_pos >= win_lo) &&
                   ((search_depth_r == 16'd0) || (start_pos < win_hi));
    hit          = enough_bytes && in_window && all_ok;
  end

  // Packet state update; the last byte clears it.
  always_comb begin
    pos_nxt   = pos_r;
    found_nxt = found_r;
    if (s1_adv) begin
      if (s1_last_r) begin
        pos_nxt   = '0;
        found_nxt = 1'b0;
      end else begin
        found_nxt = found_r || hit;
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + POSITION_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      found_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      found_r <= found_nxt;
    end
  end

  // History shift line. Only bytes of the current packet are ever compared.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      hist_r[0] <= s1_byte_r;
      for (int i = 1; i < HIST_LEN; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  // Result register, loaded on the last byte of a packet.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_match_found_r <= found_r || hit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_found = out_match_found_r;

`ifndef ASSERT_OFF
  // A last byte leaves the packet state clear.
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> ((pos_r == '0) && !found_r))
    else $error("packet state not cleared after last byte");

  // No match can have been recorded before the first byte of a packet.
  a_no_found_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == '0) |-> !found_r)
    else $error("found flag set at packet start");

  // An empty input register always takes a byte.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_ready)
    else $error("input stalled while input register empty");

  // The position steps by one per byte until it saturates.
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_last_r && (pos_r != POS_MAX)) |=>
      (pos_r == $past(pos_r) + POSITION_BITS'(1)))
    else $error("byte position did not advance");
`endif

endmodule

`default_nettype wire
